[rtl/lwd_pkg.sv]
// lwd_pkg: types and fixed constants of the least-work dispatcher
// holds the input and result word structs; no dependencies
package lwd_pkg;

    localparam int ID_W   = 16;
    localparam int FACT_W = 8;
    localparam int TIME_W = 16;
    localparam int CFG_W  = 3;
    localparam int SIDX_W = 2;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 3'd4;

    typedef struct packed {
        logic              operation;
        logic [ID_W-1:0]   job_id;
        logic [FACT_W-1:0] weight;
        logic [FACT_W-1:0] count;
    } lwd_in_t;

    typedef struct packed {
        logic [SIDX_W-1:0] server_index;
        logic              accepted;
        logic              busy_res;
        logic [ID_W-1:0]   head_job_id;
        logic [TIME_W-1:0] remaining;
        logic              completed;
        logic              any_pending;
        logic              last;
    } lwd_out_t;

endpackage

[rtl/lwd_job_ram.sv]
// lwd_job_ram: single write port, single registered read port job store
// no package dependency
module lwd_job_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/least_work_dispatch_fcfs_top.sv]
// least_work_dispatch_fcfs_top: join-least-work FCFS dispatcher over several server queues
// depends on lwd_pkg and lwd_job_ram
//
// usage
//   command channel: drive req and raise start; the word is taken at a clock edge with
//   start high and busy low. busy stays high until the last result word shows.
//   result channel: each word sits on res for one cycle with res_strobe high; there is
//   no back-pressure, the receiver must take it. the last word of an item has res.last.
//   configuration: cfg_we with cfg_data writes the active server count, idle only.
//   an arrival walks the n active servers with one shared compare, one per cycle, then
//   queues the job and gives a single result word. a tick visits each active server
//   through the one job store port: an idle server is only checked, a busy one is read,
//   then updated; then it plays out n result words on consecutive cycles.
//   one item at a time; the next can be taken in the cycle the last result shows.
//   reset empties all queues and sets the active count to four; the job store itself
//   is not cleared, only data from occupied slots is ever used.
module least_work_dispatch_fcfs_top #(
    parameter int NUM_SERVERS = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  lwd_pkg::lwd_in_t         req,
    output logic                     res_strobe,
    output lwd_pkg::lwd_out_t        res,
    input  logic                     cfg_we,
    input  logic [lwd_pkg::CFG_W-1:0] cfg_data
);

    import lwd_pkg::*;

    localparam int SRV_W   = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int WORK_W  = TIME_W + SLOT_W;
    localparam int ADDR_W  = SRV_W + SLOT_W;
    localparam int ENTRY_W = ID_W + TIME_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_PLACE = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [SRV_W-1:0]  cur_reg, cur_next;
    logic [SRV_W-1:0]  best_reg, best_next;
    logic [CFG_W-1:0]  active_reg;
    logic [FILL_W-1:0] fill_reg [NUM_SERVERS];
    logic [FILL_W-1:0] fill_next [NUM_SERVERS];
    logic [SLOT_W-1:0] head_reg [NUM_SERVERS];
    logic [SLOT_W-1:0] head_next [NUM_SERVERS];
    logic [WORK_W-1:0] work_reg [NUM_SERVERS];
    logic [WORK_W-1:0] work_next [NUM_SERVERS];
    logic              strobe_reg, strobe_next;

    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] svc_reg;
    logic [WORK_W-1:0] best_work_reg, best_work_next;
    logic              t_busy_reg [NUM_SERVERS];
    logic              t_done_reg [NUM_SERVERS];
    logic [ID_W-1:0]   t_hid_reg [NUM_SERVERS];
    logic [TIME_W-1:0] t_rem_reg [NUM_SERVERS];
    lwd_out_t          res_reg, res_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [SRV_W-1:0]  last_idx;
    logic              pend;
    logic [FILL_W-1:0] cur_fill;
    logic [SLOT_W-1:0] cur_head;
    logic [WORK_W-1:0] cur_work;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] head_inc;
    logic              place_ok;
    logic              take;
    logic              at_last;
    logic [TIME_W-1:0] new_rem;

    lwd_job_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // active count clamped to 1..NUM_SERVERS, kept as the last server index
    always_comb
    begin
        if (active_reg == '0)
        begin
            last_idx = '0;
        end
        else if (int'(active_reg) > NUM_SERVERS)
        begin
            last_idx = SRV_W'(NUM_SERVERS - 1);
        end
        else
        begin
            last_idx = SRV_W'(active_reg - 1'b1);
        end
    end

    always_comb
    begin
        pend = 1'b0;
        for (int i = 0; i < NUM_SERVERS; i++)
        begin
            pend = pend | (fill_reg[i] != '0);
        end
    end

    assign cur_fill = fill_reg[cur_reg];
    assign cur_head = head_reg[cur_reg];
    assign cur_work = work_reg[cur_reg];
    assign at_last  = (cur_reg == last_idx);

    // tail slot, wrapping at the queue depth
    assign slot_sum = (SLOT_W + 1)'(cur_head) + (SLOT_W + 1)'(cur_fill);
    assign slot     = (slot_sum >= (SLOT_W + 1)'(QUEUE_DEPTH))
                      ? SLOT_W'(slot_sum - (SLOT_W + 1)'(QUEUE_DEPTH))
                      : SLOT_W'(slot_sum);
    assign head_inc = (cur_head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
    assign place_ok = (svc_reg != '0) && (cur_fill < FILL_W'(QUEUE_DEPTH));
    assign take     = (cur_reg == '0) || (cur_work < best_work_reg);
    assign new_rem  = ram_rdata[TIME_W-1:0] - TIME_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        best_work_next = best_work_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        work_next      = work_reg;
        strobe_next    = 1'b0;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = {cur_reg, slot};
        ram_wdata      = {id_reg, svc_reg};
        ram_raddr      = {cur_reg, cur_head};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cur_next = '0;
                    if (req.operation == OP_TICK)
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (take)
                begin
                    best_next      = cur_reg;
                    best_work_next = cur_work;
                end
                if (at_last)
                begin
                    state_next = ST_PLACE;
                    cur_next   = take ? cur_reg : best_reg;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end

            ST_PLACE:
            begin
                if (place_ok)
                begin
                    ram_we             = 1'b1;
                    fill_next[cur_reg] = cur_fill + 1'b1;
                    work_next[cur_reg] = cur_work + WORK_W'(svc_reg);
                end
                res_next.server_index = SIDX_W'(cur_reg);
                res_next.accepted     = place_ok;
                res_next.busy_res     = 1'b0;
                res_next.head_job_id  = '0;
                res_next.remaining    = '0;
                res_next.completed    = 1'b0;
                res_next.any_pending  = pend | place_ok;
                res_next.last         = 1'b1;
                strobe_next           = 1'b1;
                state_next            = ST_IDLE;
            end

            ST_RD:
            begin
                if (cur_fill != '0)
                begin
                    state_next = ST_UPD;
                end
                else if (at_last)
                begin
                    state_next = ST_EMIT;
                    cur_next   = '0;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end

            ST_UPD:
            begin
                ram_we    = 1'b1;
                ram_waddr = {cur_reg, cur_head};
                ram_wdata = {ram_rdata[ENTRY_W-1:TIME_W], new_rem};
                if (cur_work != '0)
                begin
                    work_next[cur_reg] = cur_work - 1'b1;
                end
                if (new_rem == '0)
                begin
                    head_next[cur_reg] = head_inc;
                    fill_next[cur_reg] = cur_fill - 1'b1;
                end
                if (at_last)
                begin
                    state_next = ST_EMIT;
                    cur_next   = '0;
                end
                else
                begin
                    state_next = ST_RD;
                    cur_next   = cur_reg + 1'b1;
                end
            end

            ST_EMIT:
            begin
                res_next.server_index = SIDX_W'(cur_reg);
                res_next.accepted     = 1'b0;
                res_next.busy_res     = t_busy_reg[cur_reg];
                res_next.head_job_id  = t_busy_reg[cur_reg] ? t_hid_reg[cur_reg] : '0;
                res_next.remaining    = t_busy_reg[cur_reg] ? t_rem_reg[cur_reg] : '0;
                res_next.completed    = t_done_reg[cur_reg];
                res_next.any_pending  = pend;
                res_next.last         = at_last;
                strobe_next           = 1'b1;
                if (at_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cur_reg    <= '0;
            best_reg   <= '0;
            strobe_reg <= 1'b0;
            active_reg <= ACTIVE_RESET;
            for (int i = 0; i < NUM_SERVERS; i++)
            begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
                work_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            best_reg   <= best_next;
            strobe_reg <= strobe_next;
            fill_reg   <= fill_next;
            head_reg   <= head_next;
            work_reg   <= work_next;
            if (cfg_we)
            begin
                active_reg <= cfg_data;
            end
        end
    end

    // captured command fields, result word and per-server tick outcome, held until played out
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            id_reg  <= req.job_id;
            svc_reg <= TIME_W'(req.weight) * TIME_W'(req.count);
        end
        best_work_reg <= best_work_next;
        res_reg       <= res_next;
        if (state_reg == ST_RD && cur_fill == '0)
        begin
            t_busy_reg[cur_reg] <= 1'b0;
            t_done_reg[cur_reg] <= 1'b0;
        end
        if (state_reg == ST_UPD)
        begin
            t_busy_reg[cur_reg] <= 1'b1;
            t_done_reg[cur_reg] <= (new_rem == '0);
            t_hid_reg[cur_reg]  <= ram_rdata[ENTRY_W-1:TIME_W];
            t_rem_reg[cur_reg]  <= ram_rdata[TIME_W-1:0];
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign res_strobe = strobe_reg;
    assign res        = res_reg;

endmodule

[rtl/lwd_checker.sv]
// lwd_checker: port-level checks on the dispatcher's command and result words
// depends on lwd_pkg; bound to least_work_dispatch_fcfs_top below
module lwd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              res_strobe,
    input lwd_pkg::lwd_out_t res
);

    import lwd_pkg::*;

    // a taken command word keeps the block occupied in the next cycle
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command taken but block not busy");

    // tick results follow one another without gaps
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && !res.last |=> res_strobe)
        else $error("gap inside a result burst");

    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && res.last |=> !res_strobe)
        else $error("result word after the last one");

    // an accepted arrival is a single, last word with busy_res and completed clear
    a_arrival_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && res.accepted |-> res.last && !res.busy_res && !res.completed)
        else $error("arrival word malformed");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && res.completed |-> res.busy_res)
        else $error("completion reported for an idle server");

endmodule

bind least_work_dispatch_fcfs_top lwd_checker u_lwd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .res_strobe (res_strobe),
    .res        (res)
);

[verif/tb_least_work_dispatch_fcfs_top.sv]
// tb_least_work_dispatch_fcfs_top: self-checking bench for the least-work fcfs dispatcher
// predicts every result word from its own queue and workload copy; needs lwd_pkg and the rtl
module tb_least_work_dispatch_fcfs_top;
    import lwd_pkg::*;

    localparam int NSRV   = 4;
    localparam int QDEPTH = 16;
    localparam int SETTLE = 16;
    localparam int PHASE_WORDS = 60;

    typedef struct packed {
        lwd_in_t           word;
        logic              typed;
        logic [SIDX_W-1:0] srv;
        logic              acc;
        logic              pend;
    } dir_row_t;

    // typed rows are arrivals: only server, accepted and pending can be non-zero
    localparam dir_row_t DIRECTED [16] = '{
        '{'{OP_TICK,    16'h0000, 8'd0,   8'd0},   1'b0, 2'd0, 1'b0, 1'b0},
        '{'{OP_ARRIVAL, 16'h0001, 8'd0,   8'd0},   1'b1, 2'd0, 1'b0, 1'b0},
        '{'{OP_ARRIVAL, 16'h00A5, 8'd1,   8'd1},   1'b1, 2'd0, 1'b1, 1'b1},
        '{'{OP_ARRIVAL, 16'h5A00, 8'd255, 8'd0},   1'b1, 2'd1, 1'b0, 1'b1},
        '{'{OP_ARRIVAL, 16'h8000, 8'd0,   8'd255}, 1'b1, 2'd1, 1'b0, 1'b1},
        '{'{OP_ARRIVAL, 16'h0002, 8'd2,   8'd1},   1'b1, 2'd1, 1'b1, 1'b1},
        '{'{OP_ARRIVAL, 16'h0003, 8'd1,   8'd3},   1'b1, 2'd2, 1'b1, 1'b1},
        '{'{OP_ARRIVAL, 16'hFFFF, 8'd255, 8'd255}, 1'b1, 2'd3, 1'b1, 1'b1},
        '{'{OP_TICK,    16'hFFFF, 8'd255, 8'd255}, 1'b0, 2'd0, 1'b0, 1'b0},
        '{'{OP_ARRIVAL, 16'h7FFF, 8'd128, 8'd1},   1'b1, 2'd0, 1'b1, 1'b1},
        '{'{OP_TICK,    16'h1234, 8'd7,   8'd9},   1'b0, 2'd0, 1'b0, 1'b0},
        '{'{OP_ARRIVAL, 16'h1111, 8'd1,   8'd255}, 1'b0, 2'd0, 1'b0, 1'b0},
        '{'{OP_TICK,    16'h0000, 8'd0,   8'd0},   1'b0, 2'd0, 1'b0, 1'b0},
        '{'{OP_TICK,    16'h0000, 8'd0,   8'd0},   1'b0, 2'd0, 1'b0, 1'b0},
        '{'{OP_ARRIVAL, 16'h4242, 8'd3,   8'd2},   1'b1, 2'd2, 1'b1, 1'b1},
        '{'{OP_TICK,    16'h0000, 8'd0,   8'd0},   1'b0, 2'd0, 1'b0, 1'b0}
    };

    // active server settings per random phase, both extremes and every bit pattern
    localparam logic [CFG_W-1:0] ACTIVE_SEQ [8] = '{
        3'd1, 3'd0, 3'd3, 3'd7, 3'd2, 3'd5, 3'd6, 3'd4
    };

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    logic              busy;
    lwd_in_t           req      = '0;
    logic              res_strobe;
    lwd_out_t          res;
    logic              cfg_we   = 1'b0;
    logic [CFG_W-1:0]  cfg_data = '0;

    // shadow of the dispatcher state
    logic [ID_W-1:0]   store_id   [NSRV][QDEPTH];
    logic [TIME_W-1:0] store_left [NSRV][QDEPTH];
    logic [3:0]        q_head     [NSRV];
    logic [4:0]        q_fill     [NSRV];
    logic [19:0]       work_sum   [NSRV];
    logic [CFG_W-1:0]  active_cfg;

    lwd_out_t    due [$];
    int unsigned errors      = 0;
    int unsigned words_sent  = 0;
    int unsigned results_seen = 0;
    int unsigned jobs_done   = 0;
    int unsigned zero_refused = 0;
    int unsigned full_refused = 0;

    least_work_dispatch_fcfs_top #(
        .NUM_SERVERS (NSRV),
        .QUEUE_DEPTH (QDEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .res_strobe (res_strobe),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 200000);
        $display("status: fail");
        $finish;
    end

    // 0 acts as 1, anything above the server count as the server count
    function automatic int served_count();
        if (active_cfg == 0)
            return 1;
        if (active_cfg > NSRV)
            return NSRV;
        return int'(active_cfg);
    endfunction

    function automatic logic anything_queued();
        for (int s = 0; s < NSRV; s++)
            if (q_fill[s] != 0)
                return 1'b1;
        return 1'b0;
    endfunction

    // add one expected word at the tail of the queue
    function automatic void expect_word(input lwd_out_t r);
        due.insert(due.size(), r);
    endfunction

    // dispatch or serve one accepted word and queue up the result words it causes
    task automatic dispatch_and_serve(input lwd_in_t w);
        int          n;
        int          best;
        logic [15:0] svc;
        logic [3:0]  slot;
        logic        pend;
        lwd_out_t    r;
        lwd_out_t    tick_res [NSRV];
        n = served_count();
        if (w.operation == OP_ARRIVAL)
        begin
            svc  = 16'(w.weight) * 16'(w.count);
            best = 0;
            for (int s = 1; s < n; s++)
                if (work_sum[s] < work_sum[best])
                    best = s;
            r = '0;
            r.server_index = SIDX_W'(best);
            if (svc == 0)
                zero_refused++;
            else if (q_fill[best] >= QDEPTH)
                full_refused++;
            else
            begin
                slot = q_head[best] + q_fill[best][3:0];
                store_id[best][slot]   = w.job_id;
                store_left[best][slot] = svc;
                q_fill[best]   = q_fill[best] + 1'b1;
                work_sum[best] = work_sum[best] + svc;
                r.accepted = 1'b1;
            end
            r.any_pending = anything_queued();
            r.last = 1'b1;
            expect_word(r);
        end
        else
        begin
            for (int s = 0; s < n; s++)
            begin
                tick_res[s] = '0;
                tick_res[s].server_index = SIDX_W'(s);
                if (q_fill[s] != 0)
                begin
                    slot = q_head[s];
                    tick_res[s].busy_res    = 1'b1;
                    tick_res[s].head_job_id = store_id[s][slot];
                    tick_res[s].remaining   = store_left[s][slot];
                    store_left[s][slot] = store_left[s][slot] - 1'b1;
                    if (work_sum[s] != 0)
                        work_sum[s] = work_sum[s] - 1'b1;
                    if (store_left[s][slot] == 0)
                    begin
                        q_head[s] = q_head[s] + 1'b1;
                        q_fill[s] = q_fill[s] - 1'b1;
                        tick_res[s].completed = 1'b1;
                        jobs_done++;
                    end
                end
            end
            pend = anything_queued();
            for (int s = 0; s < n; s++)
            begin
                tick_res[s].any_pending = pend;
                tick_res[s].last = (s == n - 1);
                expect_word(tick_res[s]);
            end
        end
    endtask

    // start is only lowered when a gap is taken, so a back-to-back word keeps it high
    task automatic send_word(input lwd_in_t w, input int idle_pct);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req   <= w;
        start <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        dispatch_and_serve(w);
        words_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic void check_field(input string fname, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        lwd_out_t want;
        if (rst_n === 1'b1 && res_strobe !== 1'b0)
        begin
            results_seen++;
            if (due.size() == 0)
            begin
                $display("%0t: result word with none expected, expected nothing, actual %h",
                         $time, res);
                errors++;
            end
            else
            begin
                want = due.pop_front();
                check_field("server_index", 16'(want.server_index), 16'(res.server_index));
                check_field("accepted",     16'(want.accepted),     16'(res.accepted));
                check_field("busy_res",     16'(want.busy_res),     16'(res.busy_res));
                check_field("head_job_id",  want.head_job_id,       res.head_job_id);
                check_field("remaining",    want.remaining,         res.remaining);
                check_field("completed",    16'(want.completed),    16'(res.completed));
                check_field("any_pending",  16'(want.any_pending),  16'(res.any_pending));
                check_field("last",         16'(want.last),         16'(res.last));
            end
        end
    end

    initial
    begin
        lwd_in_t w;
        int      idle_pct;
        int      tick_pct;
        int      pick;
        for (int s = 0; s < NSRV; s++)
        begin
            q_head[s]   = '0;
            q_fill[s]   = '0;
            work_sum[s] = '0;
        end
        active_cfg = ACTIVE_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_word(DIRECTED[i].word, 0);
            if (DIRECTED[i].typed)
            begin
                w = '0;
                due[due.size() - 1] = '{server_index: DIRECTED[i].srv,
                                        accepted:     DIRECTED[i].acc,
                                        any_pending:  DIRECTED[i].pend,
                                        last:         1'b1,
                                        default:      '0};
            end
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            cfg_we   <= 1'b1;
            cfg_data <= ACTIVE_SEQ[ph];
            @(posedge clk);
            cfg_we   <= 1'b0;
            active_cfg = ACTIVE_SEQ[ph];
            idle_pct = (ph < 3) ? 7 : (ph < 6) ? 54 : 0;
            // a lone server gets few ticks so its queue runs full
            tick_pct = (served_count() == 1) ? 25 : 45;
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (k == PHASE_WORDS / 2)
                    wait_drained();
                w.job_id = 16'($urandom);
                if ($urandom_range(99) < tick_pct)
                begin
                    // fields other than the operation are don't-care on a tick
                    w.operation = OP_TICK;
                    w.weight    = 8'($urandom);
                    w.count     = 8'($urandom);
                end
                else
                begin
                    w.operation = OP_ARRIVAL;
                    w.weight    = 8'($urandom_range(1, 4));
                    w.count     = 8'($urandom_range(1, 4));
                    pick = $urandom_range(99);
                    if (pick < 5)
                        w.weight = '0;
                    else if (pick < 9)
                        w.count = '0;
                    else if (pick < 13)
                    begin
                        w.weight = 8'($urandom);
                        w.count  = 8'd1;
                    end
                    else if (pick < 17)
                    begin
                        w.weight = 8'd1;
                        w.count  = 8'($urandom);
                    end
                end
                send_word(w, idle_pct);
            end
        end
        wait_drained();

        $display("ran %0d words over 8 active-server settings, %0d result words checked",
                 words_sent, results_seen);
        $display("%0d jobs finished, %0d refused for zero time, %0d refused on a full queue",
                 jobs_done, zero_refused, full_refused);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
